FILE: src/stpq_pkg.sv
`default_nettype none
package stpq_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CHANGE = 3'd3;
  localparam logic [2:0] OP_LEVEL  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [7:0] MIN_PER_HOUR = 8'd60;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic [9:0]  hours;
    logic [5:0]  minutes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_task_id;
    logic [7:0]  out_priority;
    logic [9:0]  out_hours;
    logic [5:0]  out_minutes;
    logic [15:0] total_hours;
    logic [5:0]  total_minutes;
    logic [5:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  pri;
    logic [9:0]  hrs;
    logic [5:0]  mins;
  } entry_t;

  typedef struct packed {
    logic [15:0] hrs;
    logic [5:0]  mins;
  } hm_t;

  // add hours/minutes into an accumulator whose minutes are below 60
  function automatic hm_t hm_add(hm_t acc, logic [9:0] h, logic [5:0] m);
    logic [7:0] t;
    logic [1:0] c;
    hm_t        r;
    t = {2'b00, acc.mins} + {2'b00, m};
    if (t >= 2 * MIN_PER_HOUR) begin
      c = 2'd2;
    end else if (t >= MIN_PER_HOUR) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    r.mins = 6'(t - 8'(c) * MIN_PER_HOUR);
    r.hrs  = acc.hrs + {6'd0, h} + {14'd0, c};
    return r;
  endfunction

  // take hours/minutes back out, borrowing 60 minutes as often as needed
  function automatic hm_t hm_sub(hm_t acc, logic [9:0] h, logic [5:0] m);
    logic [7:0] t;
    logic [7:0] mm;
    logic [1:0] b;
    hm_t        r;
    t  = {2'b00, acc.mins};
    mm = {2'b00, m};
    if (mm > t + MIN_PER_HOUR) begin
      b = 2'd2;
    end else if (mm > t) begin
      b = 2'd1;
    end else begin
      b = 2'd0;
    end
    r.mins = 6'(t + 8'(b) * MIN_PER_HOUR - mm);
    r.hrs  = acc.hrs - {14'd0, b} - {6'd0, h};
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/sorted_task_priority_queue.sv
`default_nettype none
// Sorted task queue: holds up to DEPTH tasks in ascending priority order in a
// single-port-read memory, walked by one sequencer that touches one entry at a
// time (read, then compare/move). A push or priority change shifts the
// entries above the insertion point, a remove shifts those above the hole, and
// a level query scans every held entry, so the work for an item grows with the
// number of held tasks (most for a priority change); pop and refused
// operations do not walk the list. in_stall stays high while an item is being
// worked; one result register lets the next item enter while a result still
// waits on out_stall.
module sorted_task_priority_queue #(
  parameter int unsigned DEPTH = stpq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire stpq_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output stpq_pkg::out_item_t     out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_INS_RD  = 12'b0000_0000_0010,
    S_INS_CK  = 12'b0000_0000_0100,
    S_FIND_RD = 12'b0000_0000_1000,
    S_FIND_CK = 12'b0000_0001_0000,
    S_DEL_RD  = 12'b0000_0010_0000,
    S_DEL_CK  = 12'b0000_0100_0000,
    S_POP_RD  = 12'b0000_1000_0000,
    S_POP_CK  = 12'b0001_0000_0000,
    S_LVL_RD  = 12'b0010_0000_0000,
    S_LVL_CK  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  stpq_pkg::hm_t         sum_r, sum_nxt;
  stpq_pkg::hm_t         lvl_r, lvl_nxt;
  stpq_pkg::in_item_t    req_r, req_nxt;
  stpq_pkg::entry_t      task_r, task_nxt;
  stpq_pkg::entry_t      pop_r, pop_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  stpq_pkg::out_item_t   out_r, out_nxt;

  stpq_pkg::entry_t      mem [DEPTH];
  stpq_pkg::entry_t      rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  stpq_pkg::entry_t      mem_wd;
  logic [CW-1:0]         ptr_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign ptr_inc   = ptr_r + CW'(1);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    lvl_nxt       = lvl_r;
    req_nxt       = req_r;
    task_nxt      = task_r;
    pop_nxt       = pop_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rd_addr       = ptr_r[AW-1:0];
    mem_we        = 1'b0;
    mem_wa        = ptr_r[AW-1:0];
    mem_wd        = task_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          pop_nxt    = '0;
          lvl_nxt    = '0;
          status_nxt = stpq_pkg::ST_OK;
          ptr_nxt    = '0;
          unique case (in_data.opcode) inside
            stpq_pkg::OP_PUSH: begin
              if (cnt_r == CW'(DEPTH)) begin
                status_nxt = stpq_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                task_nxt  = '{id: in_data.task_id, pri: in_data.priority_req,
                              hrs: in_data.hours, mins: in_data.minutes};
                ptr_nxt   = cnt_r;
                state_nxt = S_INS_RD;
              end
            end
            stpq_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = stpq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = cnt_r - CW'(1);
                state_nxt = S_POP_RD;
              end
            end
            stpq_pkg::OP_REMOVE, stpq_pkg::OP_CHANGE: begin
              if (cnt_r == '0) begin
                status_nxt = stpq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_FIND_RD;
              end
            end
            stpq_pkg::OP_LEVEL: state_nxt = S_LVL_RD;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        if (ptr_r == '0) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          if (req_r.opcode == stpq_pkg::OP_PUSH) begin
            sum_nxt = stpq_pkg::hm_add(sum_r, task_r.hrs, task_r.mins);
          end
          state_nxt = S_DONE;
        end else begin
          rd_addr   = AW'(ptr_r - CW'(1));
          state_nxt = S_INS_CK;
        end
      end
      S_INS_CK: begin
        mem_we = 1'b1;
        if (rd_data_r.pri > task_r.pri) begin
          // move the larger entry up one slot and keep walking down
          mem_wd    = rd_data_r;
          ptr_nxt   = ptr_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          if (req_r.opcode == stpq_pkg::OP_PUSH) begin
            sum_nxt = stpq_pkg::hm_add(sum_r, task_r.hrs, task_r.mins);
          end
          state_nxt = S_DONE;
        end
      end
      S_FIND_RD: begin
        if (ptr_r == cnt_r) begin
          status_nxt = stpq_pkg::ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FIND_CK;
        end
      end
      S_FIND_CK: begin
        if (rd_data_r.id == req_r.task_id) begin
          task_nxt  = rd_data_r;
          state_nxt = S_DEL_RD;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_FIND_RD;
        end
      end
      S_DEL_RD: begin
        if (ptr_inc >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          if (req_r.opcode == stpq_pkg::OP_REMOVE) begin
            sum_nxt   = stpq_pkg::hm_sub(sum_r, task_r.hrs, task_r.mins);
            state_nxt = S_DONE;
          end else begin
            task_nxt.pri = req_r.priority_req;
            ptr_nxt      = cnt_r - CW'(1);
            state_nxt    = S_INS_RD;
          end
        end else begin
          rd_addr   = ptr_inc[AW-1:0];
          state_nxt = S_DEL_CK;
        end
      end
      S_DEL_CK: begin
        mem_we    = 1'b1;
        mem_wd    = rd_data_r;
        ptr_nxt   = ptr_inc;
        state_nxt = S_DEL_RD;
      end
      S_POP_RD: state_nxt = S_POP_CK;
      S_POP_CK: begin
        pop_nxt   = rd_data_r;
        cnt_nxt   = cnt_r - CW'(1);
        sum_nxt   = stpq_pkg::hm_sub(sum_r, rd_data_r.hrs, rd_data_r.mins);
        state_nxt = S_DONE;
      end
      S_LVL_RD: begin
        state_nxt = (ptr_r == cnt_r) ? S_DONE : S_LVL_CK;
      end
      S_LVL_CK: begin
        if (rd_data_r.pri == req_r.priority_req) begin
          lvl_nxt = stpq_pkg::hm_add(lvl_r, rd_data_r.hrs, rd_data_r.mins);
        end
        ptr_nxt   = ptr_inc;
        state_nxt = S_LVL_RD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = status_r;
          out_nxt.out_task_id   = pop_r.id;
          out_nxt.out_priority  = pop_r.pri;
          out_nxt.out_hours     = pop_r.hrs;
          out_nxt.out_minutes   = pop_r.mins;
          if (req_r.opcode == stpq_pkg::OP_LEVEL) begin
            out_nxt.total_hours   = lvl_r.hrs;
            out_nxt.total_minutes = lvl_r.mins;
          end else begin
            out_nxt.total_hours   = sum_r.hrs;
            out_nxt.total_minutes = sum_r.mins;
          end
          out_nxt.entry_count   = 6'(cnt_r);
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_INS_CK && !(rd_data_r.pri > task_r.pri)) begin
      mem_wd = task_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    lvl_r    <= lvl_nxt;
    req_r    <= req_nxt;
    task_r   <= task_nxt;
    pop_r    <= pop_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

FILE: src/stpq_checker.sv
`default_nettype none
module stpq_checker #(
  parameter int unsigned DEPTH = stpq_pkg::DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire stpq_pkg::out_item_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("ready right after accept");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == stpq_pkg::ST_FULL |->
      out_data.entry_count == 6'(DEPTH))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == stpq_pkg::ST_EMPTY |->
      out_data.entry_count == 6'd0)
    else $error("empty status with entries held");

  a_minutes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.total_minutes < 6'd60)
    else $error("minutes not carried");

endmodule

bind sorted_task_priority_queue stpq_checker #(.DEPTH(DEPTH)) u_stpq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  class task_queue_scoreboard;
    stpq_pkg::entry_t    tasks[$];
    logic [15:0]         run_hours;
    logic [5:0]          run_minutes;
    stpq_pkg::out_item_t pending_results[$];
    int                  error_count;
    int                  checked_count;

    function new();
      run_hours = 0;
      run_minutes = 0;
      error_count = 0;
      checked_count = 0;
    endfunction

    function void add_duration(int h, int m);
      int t;
      t = run_minutes + m;
      run_hours = 16'(run_hours + t / 60 + h);
      run_minutes = 6'(t % 60);
    endfunction

    function void take_duration(int h, int m);
      int t;
      int hh;
      t = run_minutes;
      hh = run_hours;
      while (m > t) begin
        hh = hh - 1;
        t = t + 60;
      end
      run_minutes = 6'(t - m);
      run_hours = 16'(hh - h);
    endfunction

    // place after every entry with priority no greater
    function void place_sorted(stpq_pkg::entry_t e);
      int pos;
      pos = tasks.size();
      while (pos > 0 && tasks[pos-1].pri > e.pri) pos--;
      tasks.insert(pos, e);
    endfunction

    function int find_task(logic [15:0] id);
      foreach (tasks[i]) if (tasks[i].id == id) return i;
      return -1;
    endfunction

    function void note_item(stpq_pkg::in_item_t it);
      stpq_pkg::out_item_t r;
      stpq_pkg::entry_t    e;
      int                  pos;
      int                  lh;
      int                  lm;
      bit                  level;
      r = '0;
      r.status = stpq_pkg::ST_OK;
      level = 0;
      lh = 0;
      lm = 0;
      case (it.opcode) inside
        stpq_pkg::OP_PUSH: begin
          if (tasks.size() >= DEPTH) begin
            r.status = stpq_pkg::ST_FULL;
          end else begin
            e.id = it.task_id;
            e.pri = it.priority_req;
            e.hrs = it.hours;
            e.mins = it.minutes;
            place_sorted(e);
            add_duration(it.hours, it.minutes);
          end
        end
        stpq_pkg::OP_POP: begin
          if (tasks.size() == 0) begin
            r.status = stpq_pkg::ST_EMPTY;
          end else begin
            e = tasks.pop_back();
            r.out_task_id = e.id;
            r.out_priority = e.pri;
            r.out_hours = e.hrs;
            r.out_minutes = e.mins;
            take_duration(e.hrs, e.mins);
          end
        end
        stpq_pkg::OP_REMOVE, stpq_pkg::OP_CHANGE: begin
          if (tasks.size() == 0) begin
            r.status = stpq_pkg::ST_EMPTY;
          end else begin
            pos = find_task(it.task_id);
            if (pos < 0) begin
              r.status = stpq_pkg::ST_NOTFOUND;
            end else begin
              e = tasks[pos];
              tasks.delete(pos);
              if (it.opcode == stpq_pkg::OP_REMOVE) begin
                take_duration(e.hrs, e.mins);
              end else begin
                e.pri = it.priority_req;
                place_sorted(e);
              end
            end
          end
        end
        stpq_pkg::OP_LEVEL: begin
          level = 1;
          foreach (tasks[i]) begin
            if (tasks[i].pri == it.priority_req) begin
              lh = (lh + tasks[i].hrs) & 16'hFFFF;
              lm = lm + tasks[i].mins;
              lh = (lh + lm / 60) & 16'hFFFF;
              lm = lm % 60;
            end
          end
        end
        default: ;
      endcase
      r.total_hours = level ? 16'(lh) : run_hours;
      r.total_minutes = level ? 6'(lm) : run_minutes;
      r.entry_count = 6'(tasks.size());
      pending_results.push_back(r);
    endfunction

    function void check_result(stpq_pkg::out_item_t got);
      stpq_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (got.status !== want.status)
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
      if (got.out_task_id !== want.out_task_id)
        $display("%0t: task_id exp %0d got %0d", $time, want.out_task_id, got.out_task_id);
      if (got.out_priority !== want.out_priority)
        $display("%0t: priority exp %0d got %0d", $time, want.out_priority,
                 got.out_priority);
      if (got.out_hours !== want.out_hours)
        $display("%0t: hours exp %0d got %0d", $time, want.out_hours, got.out_hours);
      if (got.out_minutes !== want.out_minutes)
        $display("%0t: minutes exp %0d got %0d", $time, want.out_minutes, got.out_minutes);
      if (got.total_hours !== want.total_hours)
        $display("%0t: total_hours exp %0d got %0d", $time, want.total_hours,
                 got.total_hours);
      if (got.total_minutes !== want.total_minutes)
        $display("%0t: total_minutes exp %0d got %0d", $time, want.total_minutes,
                 got.total_minutes);
      if (got.entry_count !== want.entry_count)
        $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                 got.entry_count);
      if (got !== want) error_count++;
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_stall;
  stpq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 0;
  stpq_pkg::out_item_t out_data;

  task_queue_scoreboard board = new();
  int  idle_cycles = 0;
  int  items_sent = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  logic [15:0] used_ids[$];

  always #2 clk = ~clk;

  sorted_task_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // receiver stall pattern: long free stretches, then random stalling
  int stall_phase = 0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) board.check_result(out_data);
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(stpq_pkg::in_item_t it);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    items_sent++;
    if (it.opcode == stpq_pkg::OP_PUSH) used_ids.push_back(it.task_id);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap_left > 0) in_valid <= 0;
    end
  endtask

  function automatic stpq_pkg::in_item_t make_item(logic [2:0] op, logic [15:0] id,
                                                   logic [7:0] pri, logic [9:0] h,
                                                   logic [5:0] m);
    stpq_pkg::in_item_t it;
    it.opcode = op;
    it.task_id = id;
    it.priority_req = pri;
    it.hours = h;
    it.minutes = m;
    return it;
  endfunction

  // mostly existing ids so remove and change find something
  function automatic logic [15:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return 16'($urandom);
  endfunction

  initial begin
    stpq_pkg::in_item_t it;
    int                 fill;
    int                 wait_cycles;
    logic [2:0]         op;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty list cases
    send_item(make_item(stpq_pkg::OP_POP, 0, 0, 0, 0));
    send_item(make_item(stpq_pkg::OP_REMOVE, 16'h1234, 0, 0, 0));
    send_item(make_item(stpq_pkg::OP_CHANGE, 16'h1234, 8'd5, 0, 0));
    send_item(make_item(stpq_pkg::OP_LEVEL, 0, 8'd0, 0, 0));
    // extremes, minutes above 59, duplicates and equal priorities
    send_item(make_item(stpq_pkg::OP_PUSH, 16'hFFFF, 8'hFF, 10'h3FF, 6'h3F));
    send_item(make_item(stpq_pkg::OP_PUSH, 16'h0000, 8'h00, 10'h000, 6'd0));
    send_item(make_item(stpq_pkg::OP_PUSH, 16'h0007, 8'h10, 10'd5, 6'd59));
    send_item(make_item(stpq_pkg::OP_PUSH, 16'h0007, 8'h10, 10'd3, 6'd45));
    send_item(make_item(stpq_pkg::OP_LEVEL, 0, 8'h10, 0, 0));
    send_item(make_item(stpq_pkg::OP_REMOVE, 16'hBEEF, 0, 0, 0));
    send_item(make_item(stpq_pkg::OP_CHANGE, 16'h0007, 8'hFF, 0, 0));
    send_item(make_item(stpq_pkg::OP_REMOVE, 16'h0007, 0, 0, 0));
    send_item(make_item(stpq_pkg::OP_POP, 0, 0, 0, 0));
    send_item(make_item(3'd5, 16'hAAAA, 8'h55, 10'h2AA, 6'h15));
    send_item(make_item(3'd7, 0, 0, 0, 0));
    // fill up to refusal, with big hours and minutes above 59
    for (fill = 0; fill < DEPTH + 1; fill++)
      send_item(make_item(stpq_pkg::OP_PUSH, 16'(fill), 8'($urandom_range(0, 3)),
                          10'h3FF, 6'h3F));
    send_item(make_item(stpq_pkg::OP_LEVEL, 0, 8'd2, 0, 0));
    for (fill = 0; fill < DEPTH + 1; fill++)
      send_item(make_item(stpq_pkg::OP_POP, 0, 0, 0, 0));

    while (items_sent < 1550) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: op = stpq_pkg::OP_PUSH;
        7, 8, 9:             op = stpq_pkg::OP_POP;
        10, 11, 12:          op = stpq_pkg::OP_REMOVE;
        13, 14, 15:          op = stpq_pkg::OP_CHANGE;
        16, 17, 18:          op = stpq_pkg::OP_LEVEL;
        default:             op = 3'($urandom_range(5, 7));
      endcase
      it = make_item(op,
                     (op == stpq_pkg::OP_PUSH && $urandom_range(0, 1)) ? 16'($urandom)
                                                                       : pick_id(),
                     ($urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom)),
                     10'($urandom), ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                                 : 6'($urandom_range(0, 59)));
      send_item(it);
    end
    // a burst still holds valid high; drop it
    if (gap_left == 0) in_valid <= 0;

    wait_cycles = 0;
    while (board.pending_results.size() > 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    $display("Sent %0d items (push, pop, remove, change, level, unknown codes);", items_sent);
    $display("checked %0d results against the sorted-list predictor.", board.checked_count);
    if (board.error_count == 0 && board.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
